[design/assert_macros.svh]
// Assertion macros included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define STLF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check a consequence in the cycle after its cause.
`define STLF_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("assertion failed");

`endif

[design/stlf_pkg.sv]
// Package with constants and types of the shifted trace fit block.
`timescale 1ns / 1ps
package stlf_pkg;
  localparam int MAX_SAMPLES = 8192;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int NORM_STEPS  = 15;

  localparam logic [16:0] ONE_Q15   = 17'd32768;
  localparam logic [20:0] SAT_RATIO = 21'd589824;
  localparam logic [19:0] SCORE_MIN = 20'h80000;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_SHORT  = 2'd1;
  localparam logic [1:0] ERR_PEAK   = 2'd2;
  localparam logic [1:0] ERR_ENERGY = 2'd3;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LAG    = 1'b1;

  // Sample magnitude, 0..32768.
  typedef logic [16:0] mag_t;
endpackage

[design/stlf_norm.sv]
// Bit-serial normalizer: trunc(mag * 32768 / peak), saturated at 32768.
`timescale 1ns / 1ps
module stlf_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  stlf_pkg::mag_t  mag,
  input  stlf_pkg::mag_t  peak,
  output logic            done,
  output stlf_pkg::mag_t  quo
);
  logic        busy_r;
  logic        done_r;
  logic        sat_r;
  logic [3:0]  cnt_r;
  logic [15:0] rem_r;
  logic [14:0] q_r;
  logic [16:0] peak_r;
  logic [16:0] shl;
  logic        ge;

  // One restoring step: shift in a zero, subtract when it fits.
  assign shl = {rem_r, 1'b0};
  assign ge  = shl >= peak_r;

  // Control of the step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(stlf_pkg::NORM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= mag[15:0];
      sat_r  <= mag >= peak;
      peak_r <= peak;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 16'(shl - peak_r) : shl[15:0];
      q_r   <= {q_r[13:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = sat_r ? stlf_pkg::ONE_Q15 : {2'b00, q_r};
endmodule

[design/shifted_trace_l2_fit.sv]
// Top level of the shifted trace least-squares fit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
// Sample pairs enter on the in_ channel, one request per cycle while loading;
// the pair with in_tlast set ends the trace and starts the fit. No input is
// taken until the fit has finished and its result has been moved into the
// output register. The out_ channel carries one result per trace: score in
// Q4.16 and an error code. Configuration writes on cfg_ are taken at once,
// and must be issued only while the block is idle; the block itself does not enforce this.
// After the last pair, a short trace goes straight to the result; else a peak
// scan runs over the window indices lo..hi, then each window index whose
// shifted partner lies inside the trace is passed through the bit-serial
// normalizers and accumulated while every other index is skipped, and then
// the ratio division runs. The fit pass is set by the sample memories, which
// deliver one pair of samples per cycle, and by the normalizers.
// Reset clears the sample counter, sums and peaks, restores window_center = 64 and
// lag_shift = 0; memory contents are not cleared. When the receiver stalls,
// the result is held in the output register and the next trace may still
// load; a second result waits until the first is taken.
module shifted_trace_l2_fit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] first_sample, [31:16] second_sample
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [19:0] score, [21:20] error_code, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int AW = stlf_pkg::ADDR_W;
  localparam int CW = stlf_pkg::CNT_W;

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_PEAK      = 4'd2;
  localparam logic [3:0] S_PEAK_END  = 4'd3;
  localparam logic [3:0] S_PEAK_CHK  = 4'd4;
  localparam logic [3:0] S_FIT_ADDR  = 4'd5;
  localparam logic [3:0] S_FIT_START = 4'd6;
  localparam logic [3:0] S_FIT_DIV   = 4'd7;
  localparam logic [3:0] S_FIT_MUL   = 4'd8;
  localparam logic [3:0] S_FIT_ACC   = 4'd9;
  localparam logic [3:0] S_FINAL     = 4'd10;
  localparam logic [3:0] S_DIV       = 4'd11;
  localparam logic [3:0] S_SCORE     = 4'd12;
  localparam logic [3:0] S_EMIT      = 4'd13;

  logic [3:0]         state_r, state_nxt;
  logic [11:0]        win_r;
  logic [12:0]        lag_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      idx_r;
  logic [47:0]        mis_r, en_r;
  stlf_pkg::mag_t     pk_a_r, pk_b_r;
  logic               pk_vld_r;
  logic [15:0]        ref_rd_r, cmp_rd_r;
  logic               sgn_a_r, sgn_b_r;
  logic signed [17:0] d_r, n1_r;
  logic [32:0]        sqd_r;
  logic [30:0]        sqe_r;
  logic [67:0]        rem_r, dv_r;
  logic [20:0]        q_r;
  logic [4:0]         dcnt_r;
  logic               sat_r;
  logic [19:0]        score_r;
  logic [1:0]         err_r;
  logic               out_vld_r;
  logic [19:0]        out_score_r;
  logic [1:0]         out_err_r;

  logic [15:0] ref_mem [stlf_pkg::MAX_SAMPLES];
  logic [15:0] cmp_mem [stlf_pkg::MAX_SAMPLES];

  logic [12:0]        lo_w, hi_w, span_w;
  logic signed [14:0] j_w;
  logic               j_ok;
  logic               in_acc, wr_en;
  logic [AW-1:0]      cmp_addr;
  stlf_pkg::mag_t     mag_a, mag_b, qa, qb;
  logic               done_a, done_b, norm_start;
  logic signed [17:0] n1_w, n2_w;
  logic signed [35:0] dd_w, ee_w;
  logic               div_ge;

  // Window bounds and shifted index.
  assign lo_w   = {1'b0, win_r} - {2'b00, win_r[11:1]};
  assign hi_w   = {1'b0, win_r} + {2'b00, win_r[11:1]};
  assign span_w = {win_r, 1'b0};
  assign j_w    = $signed({2'b00, idx_r}) - $signed({{2{lag_r[12]}}, lag_r});
  assign j_ok   = !j_w[14] && (j_w[13:0] <= {1'b0, span_w});

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (count_r < CW'(stlf_pkg::MAX_SAMPLES));
  assign cmp_addr  = (state_r == S_FIT_ADDR) ? j_w[AW-1:0] : idx_r;

  // Sample memories: write while loading, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_mem[count_r[AW-1:0]] <= in_tdata[15:0];
      cmp_mem[count_r[AW-1:0]] <= in_tdata[31:16];
    end
    ref_rd_r <= ref_mem[idx_r];
    cmp_rd_r <= cmp_mem[cmp_addr];
  end

  // Magnitudes of the read samples.
  assign mag_a = ref_rd_r[15] ? 17'(~{ref_rd_r[15], ref_rd_r} + 17'd1) : {1'b0, ref_rd_r};
  assign mag_b = cmp_rd_r[15] ? 17'(~{cmp_rd_r[15], cmp_rd_r} + 17'd1) : {1'b0, cmp_rd_r};

  assign norm_start = (state_r == S_FIT_START);

  stlf_norm u_norm_a (
    .clk(clk), .rst_n(rst_n), .start(norm_start),
    .mag(mag_a), .peak(pk_a_r), .done(done_a), .quo(qa)
  );

  stlf_norm u_norm_b (
    .clk(clk), .rst_n(rst_n), .start(norm_start),
    .mag(mag_b), .peak(pk_b_r), .done(done_b), .quo(qb)
  );

  // Signed normalized values and products.
  assign n1_w   = sgn_a_r ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
  assign n2_w   = sgn_b_r ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
  assign dd_w   = d_r * d_r;
  assign ee_w   = n1_r * n1_r;
  assign div_ge = rem_r >= dv_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:      if (in_acc && in_tlast) state_nxt = S_CHECK;
      S_CHECK:     state_nxt = (count_r < CW'({1'b0, span_w} + 14'd1)) ? S_EMIT : S_PEAK;
      S_PEAK:      if (idx_r == hi_w) state_nxt = S_PEAK_END;
      S_PEAK_END:  state_nxt = S_PEAK_CHK;
      S_PEAK_CHK:  state_nxt = (pk_a_r == '0 || pk_b_r == '0) ? S_EMIT : S_FIT_ADDR;
      S_FIT_ADDR: begin
        if (idx_r > hi_w) state_nxt = S_FINAL;
        else if (j_ok) state_nxt = S_FIT_START;
      end
      S_FIT_START: state_nxt = S_FIT_DIV;
      S_FIT_DIV:   if (done_a) state_nxt = S_FIT_MUL;
      S_FIT_MUL:   state_nxt = S_FIT_ACC;
      S_FIT_ACC:   state_nxt = S_FIT_ADDR;
      S_FINAL:     state_nxt = (en_r == '0) ? S_EMIT : S_DIV;
      S_DIV:       if (dcnt_r == 5'd0) state_nxt = S_SCORE;
      S_SCORE:     state_nxt = S_EMIT;
      S_EMIT:      if (!out_vld_r || out_tready) state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  // Control state: counters, sums, peaks, configuration, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      win_r     <= 12'd64;
      lag_r     <= '0;
      count_r   <= '0;
      mis_r     <= '0;
      en_r      <= '0;
      pk_a_r    <= '0;
      pk_b_r    <= '0;
      pk_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pk_vld_r <= (state_r == S_PEAK);
      if (cfg_valid) begin
        if (cfg_index == stlf_pkg::CFG_WINDOW) win_r <= cfg_data[11:0];
        else lag_r <= cfg_data;
      end
      if (wr_en) count_r <= count_r + CW'(1);
      // Track the peak magnitudes over the window.
      if (pk_vld_r) begin
        if (mag_a > pk_a_r) pk_a_r <= mag_a;
        if (mag_b > pk_b_r) pk_b_r <= mag_b;
      end
      if (state_r == S_FIT_ACC) begin
        mis_r <= mis_r + 48'(sqd_r);
        en_r  <= en_r + 48'(sqe_r);
      end
      // Hand the result to the output register and clear for the next trace.
      if (state_r == S_EMIT && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
        count_r   <= '0;
        mis_r     <= '0;
        en_r      <= '0;
        pk_a_r    <= '0;
        pk_b_r    <= '0;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_CHECK: begin
        idx_r   <= lo_w;
        score_r <= '0;
        err_r   <= stlf_pkg::ERR_SHORT;
      end
      S_PEAK: begin
        if (idx_r != hi_w) idx_r <= idx_r + 13'd1;
      end
      S_PEAK_CHK: begin
        idx_r <= lo_w;
        err_r <= stlf_pkg::ERR_PEAK;
      end
      S_FIT_ADDR: begin
        if (idx_r <= hi_w && !j_ok) idx_r <= idx_r + 13'd1;
      end
      S_FIT_START: begin
        sgn_a_r <= ref_rd_r[15];
        sgn_b_r <= cmp_rd_r[15];
      end
      S_FIT_DIV: begin
        n1_r <= n1_w;
        d_r  <= n1_w - n2_w;
      end
      S_FIT_MUL: begin
        sqd_r <= dd_w[32:0];
        sqe_r <= ee_w[30:0];
      end
      S_FIT_ACC: idx_r <= idx_r + 13'd1;
      S_FINAL: begin
        rem_r  <= {4'b0000, mis_r, 16'h0000} + 68'(en_r[47:1]);
        dv_r   <= {en_r, 20'h00000};
        dcnt_r <= 5'd20;
        q_r    <= '0;
        sat_r  <= 1'b0;
        err_r  <= stlf_pkg::ERR_ENERGY;
      end
      // One quotient bit per cycle; a top bit means the ratio is out of range.
      S_DIV: begin
        if (div_ge) rem_r <= rem_r - dv_r;
        if (dcnt_r == 5'd20 && div_ge) sat_r <= 1'b1;
        q_r    <= {q_r[19:0], div_ge};
        dv_r   <= dv_r >> 1;
        dcnt_r <= dcnt_r - 5'd1;
      end
      S_SCORE: begin
        err_r <= stlf_pkg::ERR_OK;
        if (sat_r || q_r >= stlf_pkg::SAT_RATIO) score_r <= stlf_pkg::SCORE_MIN;
        else score_r <= 20'(21'd65536 - q_r);
      end
      S_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_score_r <= score_r;
          out_err_r   <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_err_r, out_score_r};

  `STLF_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(stlf_pkg::MAX_SAMPLES))
  `STLF_ASSERT_ALWAYS(a_norm_lockstep, done_a == done_b)
  `STLF_ASSERT_ALWAYS(a_err_zero_score, !out_vld_r || out_err_r == stlf_pkg::ERR_OK || out_score_r == '0)
  `STLF_ASSERT_NEXT(a_last_stops_load, in_acc && in_tlast, !in_tready)
endmodule
